// ----- hdl/relo_pkg.sv -----
// package with shared constants, widths and a helper function of the ring entry offset locator
`timescale 1ns / 1ps
package relo_pkg;
   localparam int DEPTH    = 10;
   localparam int SLOT_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int HANDLE_W = 32;
   localparam int SIZE_W   = 16;
   localparam int OFFS_W   = 20;
   localparam int HSLOT_W  = 6;
   localparam int ENTRY_W  = HANDLE_W + SIZE_W;

   localparam logic REQ_ADD  = 1'b0;
   localparam logic REQ_FIND = 1'b1;

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      logic [SLOT_W-1:0] r;
      if (s == SLOT_W'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = s + 1'b1;
      end
      return r;
   endfunction
endpackage

// ----- hdl/ring_entry_offset_locator.sv -----
// top level of the ring entry offset locator: entry ring memory, pointers and offset walk
`timescale 1ns / 1ps
// A ring of entries (data handle and byte size) kept in one synchronous memory. An add
// transaction (req_tuser = 0) writes the entry at the write slot and overwrites the oldest
// entry when the ring is full. A find transaction (req_tuser = 1) walks
// the stored entries from oldest to newest, one memory read per cycle, and returns the entry
// holding the given character offset, or not found when the offset lies past the stored data.
// A find on an empty ring answers not found without a walk; otherwise the walk visits at most
// the ring depth entries, one read of the single memory read port per entry visited.
// Each transaction gives exactly one result; a new transaction is taken once the previous
// result has left or is leaving. Reset empties the ring at once, no clearing pass is needed.
module ring_entry_offset_locator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // new_handle, new_size, char_index, zero fill
   input  logic [0:0]  req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // hit_handle, hit_size, hit_slot, byte_in_entry, zero fill
   output logic [1:0]  rsp_tuser    // found, overwrote
);
   localparam logic [0:0] ST_IDLE = 1'b0;
   localparam logic [0:0] ST_WALK = 1'b1;

   logic [0:0]                      state_ff, state_in;
   logic [relo_pkg::SLOT_W-1:0]     write_ff, write_in;
   logic [relo_pkg::SLOT_W-1:0]     oldest_ff, oldest_in;
   logic                            full_ff, full_in;
   logic [relo_pkg::SLOT_W-1:0]     idx_ff, idx_in;
   logic [relo_pkg::CNT_W-1:0]      remain_ff, remain_in;
   logic [relo_pkg::OFFS_W-1:0]     offs_ff, offs_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_found_ff, rsp_found_in;
   logic                            rsp_over_ff, rsp_over_in;
   logic [relo_pkg::HANDLE_W-1:0]   rsp_handle_ff, rsp_handle_in;
   logic [relo_pkg::SIZE_W-1:0]     rsp_size_ff, rsp_size_in;
   logic [relo_pkg::HSLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic [relo_pkg::SIZE_W-1:0]     rsp_byte_ff, rsp_byte_in;

   logic                            req_accept;
   logic                            req_kind;
   logic [relo_pkg::HANDLE_W-1:0]   req_handle;
   logic [relo_pkg::SIZE_W-1:0]     req_size;
   logic [relo_pkg::OFFS_W-1:0]     req_offs;

   logic                            ram_wr_en;
   logic [relo_pkg::SLOT_W-1:0]     ram_rd_addr;
   logic [relo_pkg::ENTRY_W-1:0]    ram_wr_data;
   logic [relo_pkg::ENTRY_W-1:0]    ram_rd_data;
   logic [relo_pkg::HANDLE_W-1:0]   rd_handle;
   logic [relo_pkg::SIZE_W-1:0]     rd_size;
   logic [relo_pkg::SLOT_W-1:0]     write_next;
   logic [relo_pkg::SLOT_W-1:0]     oldest_next;
   logic [relo_pkg::CNT_W-1:0]      count;

   assign req_kind   = req_tuser[0];
   assign req_handle = req_tdata[31:0];
   assign req_size   = req_tdata[47:32];
   assign req_offs   = req_tdata[67:48];

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;

   assign ram_wr_en   = req_accept && (req_kind == relo_pkg::REQ_ADD);
   assign ram_wr_data = {req_size, req_handle};
   assign ram_rd_addr = (state_ff == ST_WALK) ? relo_pkg::next_slot(idx_ff) : oldest_ff;
   assign rd_handle   = ram_rd_data[relo_pkg::HANDLE_W-1:0];
   assign rd_size     = ram_rd_data[relo_pkg::ENTRY_W-1:relo_pkg::HANDLE_W];

   assign write_next  = relo_pkg::next_slot(write_ff);
   assign oldest_next = full_ff ? relo_pkg::next_slot(oldest_ff) : oldest_ff;
   assign count       = full_ff ? relo_pkg::CNT_W'(relo_pkg::DEPTH)
                                : relo_pkg::CNT_W'(write_ff);

   relo_ram #(
      .DATA_WIDTH (relo_pkg::ENTRY_W),
      .RAM_DEPTH  (relo_pkg::DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (write_ff),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      write_in      = write_ff;
      oldest_in     = oldest_ff;
      full_in       = full_ff;
      idx_in        = idx_ff;
      remain_in     = remain_ff;
      offs_in       = offs_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_found_in  = rsp_found_ff;
      rsp_over_in   = rsp_over_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_byte_in   = rsp_byte_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_kind == relo_pkg::REQ_ADD) begin
                  write_in      = write_next;
                  oldest_in     = oldest_next;
                  if (write_next == oldest_next) begin
                     full_in = 1'b1;
                  end
                  rsp_valid_in  = 1'b1;
                  rsp_found_in  = 1'b0;
                  rsp_over_in   = full_ff;
                  rsp_handle_in = '0;
                  rsp_size_in   = '0;
                  rsp_slot_in   = '0;
                  rsp_byte_in   = '0;
               end else if (count == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_found_in  = 1'b0;
                  rsp_over_in   = 1'b0;
                  rsp_handle_in = '0;
                  rsp_size_in   = '0;
                  rsp_slot_in   = '0;
                  rsp_byte_in   = '0;
               end else begin
                  idx_in    = oldest_ff;
                  remain_in = count;
                  offs_in   = req_offs;
                  state_in  = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (offs_ff < relo_pkg::OFFS_W'(rd_size)) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = 1'b1;
               rsp_over_in   = 1'b0;
               rsp_handle_in = rd_handle;
               rsp_size_in   = rd_size;
               rsp_slot_in   = relo_pkg::HSLOT_W'(idx_ff);
               rsp_byte_in   = offs_ff[relo_pkg::SIZE_W-1:0];
               state_in      = ST_IDLE;
            end else if (remain_ff == relo_pkg::CNT_W'(1)) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = 1'b0;
               rsp_over_in   = 1'b0;
               rsp_handle_in = '0;
               rsp_size_in   = '0;
               rsp_slot_in   = '0;
               rsp_byte_in   = '0;
               state_in      = ST_IDLE;
            end else begin
               offs_in   = offs_ff - relo_pkg::OFFS_W'(rd_size);
               remain_in = remain_ff - 1'b1;
               idx_in    = relo_pkg::next_slot(idx_ff);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         write_ff     <= '0;
         oldest_ff    <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         write_ff     <= write_in;
         oldest_ff    <= oldest_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      remain_ff     <= remain_in;
      offs_ff       <= offs_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_over_ff   <= rsp_over_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_byte_ff   <= rsp_byte_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_byte_ff, rsp_slot_ff, rsp_size_ff, rsp_handle_ff};
   assign rsp_tuser  = {rsp_over_ff, rsp_found_ff};

   // no result is pending while a walk runs
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> !rsp_valid_ff)
      else $error("result pending during walk");

   // the oldest pointer moves only once the ring is full
   assert property (@(posedge clock) disable iff (reset)
      !full_ff |-> (oldest_ff == '0))
      else $error("oldest slot moved before ring full");

   assert property (@(posedge clock) disable iff (reset)
      full_ff |-> (write_ff == oldest_ff))
      else $error("full ring with write slot apart from oldest slot");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_found_ff && rsp_over_ff))
      else $error("result both found and overwrote");
endmodule

// ----- hdl/relo_ram.sv -----
// generic single write port, single read port ram with registered read data
`timescale 1ns / 1ps
module relo_ram #(
   parameter int DATA_WIDTH = 8,
   parameter int RAM_DEPTH  = 16
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1)-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0]                         wr_data,
   input  logic [((RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1)-1:0] rd_addr,
   output logic [DATA_WIDTH-1:0]                         rd_data
);
   logic [DATA_WIDTH-1:0] mem_ff [RAM_DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- tb/sv/testbench.sv -----
// self-checking testbench for the ring entry offset locator: add and find traffic with a scoreboard
`timescale 1ns / 1ps
module testbench;
   localparam int STALL_LIMIT = 5000;
   localparam int MAX_REPORTS = 20;
   localparam int PHASE_ITEMS = 367;

   typedef struct packed {
      logic                          found;
      logic [relo_pkg::HANDLE_W-1:0] hit_handle;
      logic [relo_pkg::SIZE_W-1:0]   hit_size;
      logic [relo_pkg::HSLOT_W-1:0]  hit_slot;
      logic [relo_pkg::SIZE_W-1:0]   byte_in_entry;
      logic                          overwrote;
   } lookup_result_type;

   class ring_lookup_scoreboard;
      logic [relo_pkg::HANDLE_W-1:0] handles[relo_pkg::DEPTH];
      logic [relo_pkg::SIZE_W-1:0]   sizes[relo_pkg::DEPTH];
      int unsigned                   wr_slot;
      int unsigned                   old_slot;
      bit                            full;
      lookup_result_type             expected_q[$];
      int                            errors;
      int                            adds;
      int                            finds;
      int                            hits;
      int                            overwrites;

      function new();
         wr_slot  = 0;
         old_slot = 0;
         full     = 1'b0;
      endfunction

      function int unsigned wrap_inc(int unsigned s);
         return (s + 1 >= relo_pkg::DEPTH) ? 0 : s + 1;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // total characters held by the valid entries
      function int unsigned stored_bytes();
         int unsigned total;
         int unsigned count;
         int unsigned idx;
         total = 0;
         count = full ? relo_pkg::DEPTH : wr_slot;
         idx   = old_slot;
         for (int n = 0; n < count; n++) begin
            total += sizes[idx];
            idx = wrap_inc(idx);
         end
         return total;
      endfunction

      function void record_request(logic kind, logic [relo_pkg::HANDLE_W-1:0] handle,
                                   logic [relo_pkg::SIZE_W-1:0] size,
                                   logic [relo_pkg::OFFS_W-1:0] offs);
         lookup_result_type r;
         int unsigned       count;
         int unsigned       idx;
         int unsigned       rest;
         bit                done;
         r = '0;
         if (kind == relo_pkg::REQ_ADD) begin
            adds++;
            handles[wr_slot] = handle;
            sizes[wr_slot]   = size;
            if (full) begin
               old_slot    = wrap_inc(old_slot);
               r.overwrote = 1'b1;
               overwrites++;
            end
            wr_slot = wrap_inc(wr_slot);
            if (wr_slot == old_slot) begin
               full = 1'b1;
            end
         end else begin
            finds++;
            count = full ? relo_pkg::DEPTH : wr_slot;
            idx   = old_slot;
            rest  = offs;
            done  = 1'b0;
            for (int n = 0; n < count && !done; n++) begin
               if (rest < sizes[idx]) begin
                  r.found         = 1'b1;
                  r.hit_handle    = handles[idx];
                  r.hit_size      = sizes[idx];
                  r.hit_slot      = relo_pkg::HSLOT_W'(idx);
                  r.byte_in_entry = relo_pkg::SIZE_W'(rest);
                  done            = 1'b1;
                  hits++;
               end else begin
                  rest -= sizes[idx];
                  idx = wrap_inc(idx);
               end
            end
         end
         expected_q.push_back(r);
      endfunction

      function void compare_field(string name, longint unsigned want, longint unsigned got);
         if (want != got) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
               $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                        $time, name, want, got);
            end
         end
      endfunction

      function void check_response(logic [71:0] tdata, logic [1:0] tuser);
         lookup_result_type want;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
               $display("%0t: unexpected result, expected none, actual data 0x%0h user 0x%0h",
                        $time, tdata, tuser);
            end
         end else begin
            want = expected_q.pop_front();
            compare_field("found", want.found, tuser[0]);
            compare_field("overwrote", want.overwrote, tuser[1]);
            compare_field("hit_handle", want.hit_handle, tdata[31:0]);
            compare_field("hit_size", want.hit_size, tdata[47:32]);
            compare_field("hit_slot", want.hit_slot, tdata[53:48]);
            compare_field("byte_in_entry", want.byte_in_entry, tdata[69:54]);
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata  = '0;   // new_handle, new_size, char_index, zero fill
   logic [0:0]  req_tuser  = '0;   // req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;         // hit_handle, hit_size, hit_slot, byte_in_entry, zero fill
   logic [1:0]  rsp_tuser;         // found, overwrote

   int unsigned send_idle_pct = 11;
   int unsigned recv_idle_pct = 48;
   int          stall_cycles  = 0;

   ring_lookup_scoreboard sb = new();

   ring_entry_offset_locator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            sb.check_response(rsp_tdata, rsp_tuser);
         end
         if (req_tvalid && req_tready) begin
            sb.record_request(req_tuser[0], req_tdata[31:0], req_tdata[47:32],
                              req_tdata[67:48]);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles == STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   task automatic send_item(input logic kind, input logic [relo_pkg::HANDLE_W-1:0] handle,
                            input logic [relo_pkg::SIZE_W-1:0] size,
                            input logic [relo_pkg::OFFS_W-1:0] offs);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0, offs, size, handle};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
   endtask

   task automatic push_entry(input logic [relo_pkg::HANDLE_W-1:0] handle,
                             input logic [relo_pkg::SIZE_W-1:0] size);
      send_item(relo_pkg::REQ_ADD, handle, size, relo_pkg::OFFS_W'($urandom));
   endtask

   task automatic find_offset(input logic [relo_pkg::OFFS_W-1:0] offs);
      send_item(relo_pkg::REQ_FIND, $urandom, relo_pkg::SIZE_W'($urandom), offs);
   endtask

   // hold the sender until the block has returned everything
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic random_item();
      int unsigned total;
      logic [relo_pkg::SIZE_W-1:0] size;
      total = sb.stored_bytes();
      if ($urandom_range(1) == 0) begin
         case ($urandom_range(9))
            0:       size = '0;
            1, 2, 3: size = relo_pkg::SIZE_W'($urandom_range(64, 1));
            4:       size = relo_pkg::SIZE_W'($urandom_range(1024, 1));
            8:       size = '1;
            default: size = relo_pkg::SIZE_W'($urandom);
         endcase
         push_entry($urandom, size);
      end else begin
         case ($urandom_range(9))
            0, 1:    find_offset(relo_pkg::OFFS_W'($urandom));
            2:       find_offset(relo_pkg::OFFS_W'(total + $urandom_range(2)));
            3:       find_offset(relo_pkg::OFFS_W'((total > 0) ? total - 1 : 0));
            default: find_offset(relo_pkg::OFFS_W'((total > 0) ? $urandom_range(total - 1)
                                                                : 0));
         endcase
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty ring, then entries with extreme handles and sizes including an empty entry
      find_offset('0);
      find_offset('1);
      push_entry('1, '1);
      push_entry('0, '0);
      push_entry(32'hA5A5_5A5A, 16'd1);
      find_offset(20'd0);
      find_offset(20'd65534);
      find_offset(20'd65535);
      find_offset(20'd65536);
      find_offset('1);
      // fill the ring and wrap over the oldest entries
      for (int i = 0; i < 9; i++) begin
         push_entry(32'h1000_0000 + i, relo_pkg::SIZE_W'(i * 3 + 2));
      end
      drain();
      find_offset(20'd0);
      find_offset(relo_pkg::OFFS_W'(sb.stored_bytes() - 1));
      find_offset(relo_pkg::OFFS_W'(sb.stored_bytes()));
      find_offset('1);
      drain();

      for (int i = 0; i < PHASE_ITEMS; i++) begin
         random_item();
      end
      drain();
      send_idle_pct = 48;
      recv_idle_pct = 11;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         random_item();
      end
      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         random_item();
      end
      drain();
      repeat (30) @(posedge clock);

      $display("run covered %0d adds (%0d overwrote the oldest entry) and %0d finds",
               sb.adds, sb.overwrites, sb.finds);
      $display("%0d finds located an entry, %0d reported not found, %0d mismatches",
               sb.hits, sb.finds - sb.hits, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

// ----- sim.f -----
hdl/relo_pkg.sv
hdl/relo_ram.sv
hdl/ring_entry_offset_locator.sv
tb/sv/testbench.sv
